FILE: src/svw_pkg.sv
// ----------------------------------------------------------------------------
// svw_pkg: shared types and constants of the sv39 user page walker
// Word layouts, queue entry, status and class codes, index helper.
// ----------------------------------------------------------------------------
package svw_pkg;

	localparam int PA_W = 56;
	localparam int VA_W = 38;
	localparam int PPN_W = 44;
	localparam int IDX_W = 9;
	localparam int OFS_W = 12;
	localparam int Q_DEPTH = 2;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_RESPONSE = 1'b1;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_ANSWER = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_STATE = 2'd2;
	localparam logic [1:0] ST_NOT_MAPPED = 2'd3;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_STATE = 2'd1;

	localparam logic [1:0] LEVEL_ROOT = 2'd0;
	localparam logic [1:0] LEVEL_MID = 2'd1;
	localparam logic [1:0] LEVEL_LEAF = 2'd2;

	localparam logic CFG_ROOT = 1'b0;
	localparam logic CFG_LIVE = 1'b1;

	typedef struct packed {
		logic        op;
		logic [63:0] lookup_va;
		logic [63:0] entry_word;
		logic [1:0]  read_error;
	} in_word_t;

	typedef struct packed {
		logic            kind;
		logic [PA_W-1:0] read_address;
		logic [1:0]      status;
		logic [PA_W-1:0] xlat_pa;
		logic [3:0]      permissions;
	} out_word_t;

	typedef enum logic [2:0] {
		CLS_LK_START     = 3'd0,
		CLS_LK_INVALID   = 3'd1,
		CLS_LK_DEAD      = 3'd2,
		CLS_RSP_STATE    = 3'd3,
		CLS_RSP_INVALID  = 3'd4,
		CLS_RSP_UNMAPPED = 3'd5,
		CLS_RSP_ENTRY    = 3'd6
	} cls_t;

	typedef struct packed {
		cls_t             cls;
		logic [VA_W-1:0]  va;
		logic [PPN_W-1:0] base;
		logic [3:0]       perm;
		logic             ptr_ok;
		logic             leaf_ok;
	} cmd_t;

	function automatic logic [IDX_W-1:0] level_index(input logic [1:0] level,
			input logic [VA_W-1:0] va);
		logic [IDX_W-1:0] idx;
		case (level)
			LEVEL_ROOT: idx = {1'b0, va[37:30]};
			LEVEL_MID:  idx = va[29:21];
			default:    idx = va[20:12];
		endcase
		return idx;
	endfunction

endpackage

FILE: src/sv39_user_page_walker.sv
// ----------------------------------------------------------------------------
// sv39_user_page_walker: three-level sv39 user page-table walker
// Translates user virtual addresses by reading entries from outside memory.
// ----------------------------------------------------------------------------
// One input channel carries lookup requests and memory responses; one output
// channel carries memory read requests and final answers. A lookup either
// gets an immediate answer (invalid address, space not live) or a read of the
// root entry; each response then yields the next read or the answer.
// Responses that arrive while no walk is open are dropped without a word.
// The queue captures each input word, and the walk engine then registers the
// result that drives the output. One word a cycle is sustained while the
// output is not stalled. A full walk takes three memory round trips. The
// input queue holds QUEUE_DEPTH words; when it is full item_stall rises. A
// stalled output word holds and the engine waits, so stalls back up into the
// queue. Reset clears the configuration (root address zero, space not live),
// the queue and the walk; a lookup during a walk drops the old walk. The user
// must write configuration with cfg_write only while idle; the block itself
// does not enforce it.
// ----------------------------------------------------------------------------
module sv39_user_page_walker import svw_pkg::*; #(
	parameter int QUEUE_DEPTH = Q_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  in_word_t        item,
	output logic            result_valid,
	input  logic            result_stall,
	output out_word_t       result,
	input  logic            cfg_write,
	input  logic            cfg_index,
	input  logic [PA_W-1:0] cfg_data
);

	logic [PA_W-1:0] root_q;
	logic            live_q;
	cmd_t            front_cmd;
	cmd_t            head_cmd;
	logic            q_full;
	logic            q_not_empty;
	logic            q_pop;
	logic            push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
			live_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_ROOT: root_q <= cfg_data;
				CFG_LIVE: live_q <= cfg_data[0];
				default:  root_q <= root_q;
			endcase
		end
	end

	assign item_stall = q_full;
	assign push = item_valid && !q_full;

	svw_front u_front (
		.item (item),
		.live (live_q),
		.cmd  (front_cmd)
	);

	svw_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (front_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.head      (head_cmd),
		.not_empty (q_not_empty)
	);

	svw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_not_empty),
		.cmd          (head_cmd),
		.cmd_pop      (q_pop),
		.root         (root_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

FILE: src/svw_front.sv
// ----------------------------------------------------------------------------
// svw_front: word classifier
// Sorts each incoming word into lookup or response classes and checks entries.
// ----------------------------------------------------------------------------
module svw_front import svw_pkg::*; (
	input  in_word_t item,
	input  logic     live,
	output cmd_t     cmd
);

	logic [63:0] e;
	logic        high_clear;

	assign e = item.entry_word;
	assign high_clear = (e[63:54] == 10'd0);

	always_comb begin
		cmd.va = item.lookup_va[VA_W-1:0];
		cmd.base = e[53:10];
		cmd.perm = e[4:1];
		cmd.ptr_ok = high_clear && (e[9:0] == 10'h001);
		cmd.leaf_ok = high_clear && e[0] && e[4] && (e[3:1] != 3'd0) && !(e[2] && !e[1]);
		if (item.op == OP_LOOKUP) begin
			if (item.lookup_va[63:VA_W] != '0) begin
				cmd.cls = CLS_LK_INVALID;
			end else if (!live) begin
				cmd.cls = CLS_LK_DEAD;
			end else begin
				cmd.cls = CLS_LK_START;
			end
		end else begin
			if (item.read_error == ERR_STATE) begin
				cmd.cls = CLS_RSP_STATE;
			end else if (item.read_error != ERR_NONE) begin
				cmd.cls = CLS_RSP_INVALID;
			end else if (e == 64'd0) begin
				cmd.cls = CLS_RSP_UNMAPPED;
			end else begin
				cmd.cls = CLS_RSP_ENTRY;
			end
		end
	end

endmodule

FILE: src/svw_fifo.sv
// ----------------------------------------------------------------------------
// svw_fifo: command queue
// Small first-in first-out queue between the classifier and the walk engine.
// ----------------------------------------------------------------------------
module svw_fifo import svw_pkg::*; #(
	parameter int DEPTH = Q_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

endmodule

FILE: src/svw_back.sv
// ----------------------------------------------------------------------------
// svw_back: walk engine
// Holds the walk state, forms read requests and answers, registers the result.
// ----------------------------------------------------------------------------
module svw_back import svw_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  cmd_t            cmd,
	output logic            cmd_pop,
	input  logic [PA_W-1:0] root,
	output logic            result_valid,
	input  logic            result_stall,
	output out_word_t       result
);

	logic            busy_q;
	logic [1:0]      level_q;
	logic [VA_W-1:0] vaddr_q;
	logic            res_valid_q;
	out_word_t       res_q;

	logic            nxt_busy;
	logic [1:0]      nxt_level;
	logic            load_va;
	logic            emit;
	out_word_t       nxt_res;

	assign cmd_pop = cmd_valid && (!res_valid_q || !result_stall);
	assign result_valid = res_valid_q;
	assign result = res_q;

	always_comb begin
		nxt_busy = busy_q;
		nxt_level = level_q;
		load_va = 1'b0;
		emit = 1'b0;
		nxt_res = '0;
		nxt_res.kind = KIND_ANSWER;
		case (cmd.cls)
			CLS_LK_INVALID: begin
				emit = 1'b1;
				nxt_res.status = ST_INVALID;
			end
			CLS_LK_DEAD: begin
				emit = 1'b1;
				nxt_res.status = ST_STATE;
			end
			CLS_LK_START: begin
				emit = 1'b1;
				load_va = 1'b1;
				nxt_res.kind = KIND_READ;
				nxt_res.read_address = {root[PA_W-1:OFS_W], level_index(LEVEL_ROOT, cmd.va),
					3'b000};
			end
			CLS_RSP_STATE: begin
				emit = busy_q;
				nxt_res.status = ST_STATE;
			end
			CLS_RSP_INVALID: begin
				emit = busy_q;
				nxt_res.status = ST_INVALID;
			end
			CLS_RSP_UNMAPPED: begin
				emit = busy_q;
				nxt_res.status = ST_NOT_MAPPED;
			end
			CLS_RSP_ENTRY: begin
				emit = busy_q;
				if (level_q >= LEVEL_LEAF) begin
					if (cmd.leaf_ok) begin
						nxt_res.status = ST_OK;
						nxt_res.xlat_pa = {cmd.base, vaddr_q[OFS_W-1:0]};
						nxt_res.permissions = cmd.perm;
					end else begin
						nxt_res.status = ST_STATE;
					end
				end else if (cmd.ptr_ok) begin
					nxt_res.kind = KIND_READ;
					nxt_res.read_address = {cmd.base, level_index(level_q + 2'd1, vaddr_q),
						3'b000};
				end else begin
					nxt_res.status = ST_STATE;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
		if (emit) begin
			if (nxt_res.kind == KIND_ANSWER) begin
				nxt_busy = 1'b0;
				nxt_level = LEVEL_ROOT;
			end else if (load_va) begin
				nxt_busy = 1'b1;
				nxt_level = LEVEL_ROOT;
			end else begin
				nxt_level = level_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && load_va) begin
			vaddr_q <= cmd.va;
		end
		if (cmd_pop && emit) begin
			res_q <= nxt_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			level_q <= LEVEL_ROOT;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				busy_q <= nxt_busy;
				level_q <= nxt_level;
				res_valid_q <= emit;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_idle_level: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> level_q == LEVEL_ROOT)
		else $error("idle walker holds a nonzero level");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LEVEL_LEAF)
		else $error("walk level beyond leaf");

	a_answer_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && emit && nxt_res.kind == KIND_ANSWER) |=> !busy_q)
		else $error("walk still busy after an answer");

	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.kind == KIND_READ) |->
		(result.status == ST_OK && result.permissions == 4'd0 &&
		result.xlat_pa == '0))
		else $error("read request carries answer fields");
`endif

endmodule
